// ----- design/scrs_pkg.sv -----
// ----------------------------------------------------------------------------
// scrs_pkg: shared types and constants for the sector row span block
// Field widths, register indexes, and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package scrs_pkg;

	localparam int ROW_W      = 10;
	localparam int SLOPE_W    = 24;
	localparam int APEX_W     = 28;
	localparam int RAD_W      = 40;
	localparam int SCALE_W    = 24;
	localparam int CLIP_W     = 20;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 40;

	localparam int Y_W     = 29;  // apex_row - row*2^16
	localparam int LINE_W  = 54;  // slope*y + apex_col*2^16, Q32
	localparam int BOUND_W = 24;  // line crossing column, integer
	localparam int SQ_W    = 56;  // |y|^2
	localparam int PROD_W  = 64;  // floor(y^2/2^16) * row_scale_sq
	localparam int ROOT_W  = 28;  // half chord, Q16
	localparam int REM_W   = 30;  // root remainder
	localparam int DIFF_W  = 2 * ROOT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_SLOPE   = 4'd0,
		REG_RIGHT_SLOPE  = 4'd1,
		REG_APEX_COL     = 4'd2,
		REG_APEX_ROW     = 4'd3,
		REG_RADIUS_SQ    = 4'd4,
		REG_ROW_SCALE_SQ = 4'd5,
		REG_CLIP_COLS    = 4'd6,
		REG_CLIP_ROWS    = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [SLOPE_W-1:0] left_slope;
		logic [SLOPE_W-1:0] right_slope;
		logic [APEX_W-1:0]  apex_col;
		logic [APEX_W-1:0]  apex_row;
		logic [RAD_W-1:0]   radius_sq;
		logic [SCALE_W-1:0] row_scale_sq;
		logic [CLIP_W-1:0]  clip_cols;
		logic [CLIP_W-1:0]  clip_rows;
	} cfg_t;

	// per-row data riding along the root chain
	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic               neg;
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
	} pay_t;

	// square root working state
	typedef struct packed {
		logic [DIFF_W-1:0] xr;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

endpackage

`default_nettype wire

// ----- design/sector_clip_row_span.sv -----
// ----------------------------------------------------------------------------
// sector_clip_row_span: column span of a fan mask on one image row
// Line and circle crossings of the fan, cut to clip window and image width.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   row
// out      output     out_valid / out_stall row_out, not_empty, span_start, span_end
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One row per cycle sustained while out_stall is low; five front stages,
// a chain of 28 root cells (one root bit each), one output register.
// Reset clears all valid bits and loads the register defaults.
// Stall ripples back only through full stages, so bubbles are squeezed
// and new rows enter while a result waits at the output.
// cfg_ready is always high; writes must land only while no row is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_clip_row_span #(
	parameter int WIDTH  = 1024,
	parameter int HEIGHT = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [scrs_pkg::ROW_W-1:0]         row,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [scrs_pkg::ROW_W-1:0]              row_out,
	output logic                                    not_empty,
	output logic [scrs_pkg::ROW_W-1:0]              span_start,
	output logic [scrs_pkg::ROW_W-1:0]              span_end,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [scrs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [scrs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CELLS = scrs_pkg::ROOT_W;

	scrs_pkg::cfg_t cfg_q;

	// register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_slope   <= '0;
			cfg_q.right_slope  <= '0;
			cfg_q.apex_col     <= '0;
			cfg_q.apex_row     <= '0;
			cfg_q.radius_sq    <= '1;
			cfg_q.row_scale_sq <= 24'd65536;
			cfg_q.clip_cols    <= 20'd1047552;
			cfg_q.clip_rows    <= 20'd1047552;
		end else if (cfg_valid && cfg_ready) begin
			unique case (scrs_pkg::reg_idx_t'(cfg_index))
				scrs_pkg::REG_LEFT_SLOPE:   cfg_q.left_slope   <= cfg_data[23:0];
				scrs_pkg::REG_RIGHT_SLOPE:  cfg_q.right_slope  <= cfg_data[23:0];
				scrs_pkg::REG_APEX_COL:     cfg_q.apex_col     <= cfg_data[27:0];
				scrs_pkg::REG_APEX_ROW:     cfg_q.apex_row     <= cfg_data[27:0];
				scrs_pkg::REG_RADIUS_SQ:    cfg_q.radius_sq    <= cfg_data[39:0];
				scrs_pkg::REG_ROW_SCALE_SQ: cfg_q.row_scale_sq <= cfg_data[23:0];
				scrs_pkg::REG_CLIP_COLS:    cfg_q.clip_cols    <= cfg_data[19:0];
				scrs_pkg::REG_CLIP_ROWS:    cfg_q.clip_rows    <= cfg_data[19:0];
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	// front stages
	logic                             front_valid, front_ready;
	scrs_pkg::pay_t                   front_pay;
	logic [scrs_pkg::DIFF_W-1:0]      front_diff;
	logic                             in_ready;

	scrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.row      (row),
		.dn_valid (front_valid),
		.dn_ready (front_ready),
		.dn_pay   (front_pay),
		.dn_diff  (front_diff)
	);

	assign in_stall = !in_ready;

	// root chain: cell k settles root bit ROOT_W-1-k
	logic            c_valid [0:CELLS];
	logic            c_ready [0:CELLS];
	scrs_pkg::pay_t  c_pay   [0:CELLS];
	scrs_pkg::sqrt_t c_sq    [0:CELLS];

	assign c_valid[0]   = front_valid;
	assign front_ready  = c_ready[0];
	assign c_pay[0]     = front_pay;
	assign c_sq[0].xr   = front_diff;
	assign c_sq[0].rem  = '0;
	assign c_sq[0].root = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		scrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[k]),
			.up_ready (c_ready[k]),
			.up_pay   (c_pay[k]),
			.up_sq    (c_sq[k]),
			.dn_valid (c_valid[k+1]),
			.dn_ready (c_ready[k+1]),
			.dn_pay   (c_pay[k+1]),
			.dn_sq    (c_sq[k+1])
		);
	end

	// final bounds
	logic out_ready;
	logic signed [29:0] ax30, half30, cl30, cr30;
	logic signed [31:0] r1, r2, cl, cr, lo, hi, x0, x1, ca, cb, y0, y1, rw;
	logic fan_on, empty;
	scrs_pkg::pay_t tail;

	assign tail      = c_pay[CELLS];
	assign out_ready = !out_valid || !out_stall;
	assign c_ready[CELLS] = out_ready;

	assign ax30   = 30'(signed'(cfg_q.apex_col));
	assign half30 = $signed({2'b0, c_sq[CELLS].root});
	assign cl30   = (ax30 - half30 + 30'sd65535) >>> 16;
	assign cr30   = (ax30 + half30) >>> 16;

	always_comb begin
		fan_on = (cfg_q.left_slope != '0) || (cfg_q.right_slope != '0);
		cl = 32'(cl30);
		cr = 32'(cr30);
		lo = 32'(signed'(tail.lo));
		hi = 32'(signed'(tail.hi));
		// clip pairs, swapped when reversed
		ca = $signed({22'b0, cfg_q.clip_cols[9:0]});
		cb = $signed({22'b0, cfg_q.clip_cols[19:10]});
		x0 = (ca > cb) ? cb : ca;
		x1 = (ca > cb) ? ca : cb;
		ca = $signed({22'b0, cfg_q.clip_rows[9:0]});
		cb = $signed({22'b0, cfg_q.clip_rows[19:10]});
		y0 = (ca > cb) ? cb : ca;
		y1 = (ca > cb) ? ca : cb;
		rw = $signed({22'b0, tail.row});
		r1 = '0;
		r2 = 32'(WIDTH - 1);
		if (fan_on) begin
			if (lo > r1) r1 = lo;
			if (hi < r2) r2 = hi;
			if (!tail.neg) begin
				if (cl > r1) r1 = cl;
				if (cr < r2) r2 = cr;
			end
		end
		if (r1 < x0) r1 = x0;
		if (r2 > x1) r2 = x1;
		empty = (fan_on && tail.neg) || (r1 > r2) || (rw < y0) || (rw > y1)
			|| (rw >= 32'(HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= c_valid[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			row_out    <= tail.row;
			not_empty  <= !empty;
			span_start <= empty ? '0 : r1[scrs_pkg::ROW_W-1:0];
			span_end   <= empty ? '0 : r2[scrs_pkg::ROW_W-1:0];
		end
	end

	// input back-pressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !not_empty) |-> (span_start == '0 && span_end == '0))
		else $error("empty row carries a nonzero span");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && not_empty && WIDTH <= 1024) |-> (span_start <= span_end))
		else $error("span start beyond span end");

endmodule

`default_nettype wire

// ----- design/scrs_front.sv -----
// ----------------------------------------------------------------------------
// scrs_front: line crossings and circle term
// Five stages: row offset, products, sums, rounding, circle term compare.
// ----------------------------------------------------------------------------
`default_nettype none

module scrs_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire scrs_pkg::cfg_t                cfg,
	input  wire logic                          up_valid,
	output logic                               up_ready,
	input  wire logic [scrs_pkg::ROW_W-1:0]    row,
	output logic                               dn_valid,
	input  wire logic                          dn_ready,
	output scrs_pkg::pay_t                     dn_pay,
	output logic [scrs_pkg::DIFF_W-1:0]        dn_diff
);

	logic signed [scrs_pkg::SLOPE_W-1:0] ml0, mr0, ml, mr;
	logic signed [scrs_pkg::LINE_W-1:0]  ml_x, mr_x, y_x, base;
	logic [scrs_pkg::ROOT_W-1:0]         uy;
	logic [scrs_pkg::DIFF_W-1:0]         rad;
	logic signed [scrs_pkg::LINE_W-1:0]  lo_full, hi_full;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic r1, r2, r3, r4, r5;

	logic [scrs_pkg::ROW_W-1:0] row_s1, row_s2, row_s3, row_s4, row_s5;
	logic signed [scrs_pkg::Y_W-1:0]    y_s1;
	logic signed [scrs_pkg::LINE_W-1:0] ml_y_s2, mr_y_s2, sl_s3, sr_s3;
	logic [scrs_pkg::SQ_W-1:0]          sq_s2;
	logic [scrs_pkg::SQ_W-1:0]          plo_s3;
	logic [31:0]                        phi_s3;
	logic [scrs_pkg::BOUND_W-1:0]       lo_s4, hi_s4, lo_s5, hi_s5;
	logic [scrs_pkg::PROD_W-1:0]        prod_s4;
	logic                               neg_s5;
	logic [scrs_pkg::DIFF_W-1:0]        diff_s5;

	// slopes in order
	assign ml0  = $signed(cfg.left_slope);
	assign mr0  = $signed(cfg.right_slope);
	assign ml   = (ml0 > mr0) ? mr0 : ml0;
	assign mr   = (ml0 > mr0) ? ml0 : mr0;
	assign ml_x = scrs_pkg::LINE_W'(ml);
	assign mr_x = scrs_pkg::LINE_W'(mr);
	assign y_x  = scrs_pkg::LINE_W'(y_s1);
	assign base = $signed({{(scrs_pkg::LINE_W-scrs_pkg::APEX_W-16){cfg.apex_col[27]}},
		cfg.apex_col, 16'b0});
	assign uy   = y_s1[scrs_pkg::Y_W-1] ? scrs_pkg::ROOT_W'(-y_s1)
		: scrs_pkg::ROOT_W'(y_s1);
	assign rad  = {cfg.radius_sq, 16'b0};

	assign lo_full = (sl_s3 + 54'sd4294967295) >>> 32;
	assign hi_full = sr_s3 >>> 32;

	// ready ripples back through empty stages
	assign r5       = !v_s5 || dn_ready;
	assign r4       = !v_s4 || r5;
	assign r3       = !v_s3 || r4;
	assign r2       = !v_s2 || r3;
	assign r1       = !v_s1 || r2;
	assign up_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (r1) v_s1 <= up_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			row_s1 <= row;
			y_s1   <= $signed({cfg.apex_row[27], cfg.apex_row}) - $signed({3'b0, row, 16'b0});
		end
		if (r2) begin
			row_s2  <= row_s1;
			ml_y_s2 <= ml_x * y_x;
			mr_y_s2 <= mr_x * y_x;
			sq_s2   <= scrs_pkg::SQ_W'(uy) * scrs_pkg::SQ_W'(uy);
		end
		if (r3) begin
			row_s3 <= row_s2;
			sl_s3  <= ml_y_s2 + base;
			sr_s3  <= mr_y_s2 + base;
			// floor(y^2/2^16) split 32 + 8 bits
			plo_s3 <= scrs_pkg::SQ_W'(sq_s2[47:16]) * scrs_pkg::SQ_W'(cfg.row_scale_sq);
			phi_s3 <= 32'(sq_s2[55:48]) * 32'(cfg.row_scale_sq);
		end
		if (r4) begin
			row_s4  <= row_s3;
			lo_s4   <= lo_full[scrs_pkg::BOUND_W-1:0];
			hi_s4   <= hi_full[scrs_pkg::BOUND_W-1:0];
			prod_s4 <= scrs_pkg::PROD_W'(plo_s3) + {phi_s3, 32'b0};
		end
		if (r5) begin
			row_s5  <= row_s4;
			lo_s5   <= lo_s4;
			hi_s5   <= hi_s4;
			neg_s5  <= prod_s4 > {8'b0, rad};
			diff_s5 <= rad - prod_s4[scrs_pkg::DIFF_W-1:0];
		end
	end

	assign dn_valid   = v_s5;
	assign dn_pay.row = row_s5;
	assign dn_pay.neg = neg_s5;
	assign dn_pay.lo  = lo_s5;
	assign dn_pay.hi  = hi_s5;
	assign dn_diff    = diff_s5;

endmodule

`default_nettype wire

// ----- design/scrs_cell.sv -----
// ----------------------------------------------------------------------------
// scrs_cell: one digit of the half-chord square root
// Takes two radicand bits, yields one root bit, passes the row on.
// ----------------------------------------------------------------------------
`default_nettype none

module scrs_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire scrs_pkg::pay_t  up_pay,
	input  wire scrs_pkg::sqrt_t up_sq,
	output logic                 dn_valid,
	input  wire logic            dn_ready,
	output scrs_pkg::pay_t       dn_pay,
	output scrs_pkg::sqrt_t      dn_sq
);

	logic            v_q;
	scrs_pkg::pay_t  pay_q;
	scrs_pkg::sqrt_t sq_q;
	scrs_pkg::sqrt_t nxt;
	logic [scrs_pkg::REM_W+1:0] trial, test;

	assign up_ready = !v_q || dn_ready;

	always_comb begin
		trial  = {up_sq.rem, up_sq.xr[scrs_pkg::DIFF_W-1 -: 2]};
		test   = (scrs_pkg::REM_W+2)'({up_sq.root, 2'b01});
		nxt.xr = {up_sq.xr[scrs_pkg::DIFF_W-3:0], 2'b00};
		if (trial >= test) begin
			nxt.rem  = scrs_pkg::REM_W'(trial - test);
			nxt.root = {up_sq.root[scrs_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = scrs_pkg::REM_W'(trial);
			nxt.root = {up_sq.root[scrs_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			pay_q <= up_pay;
			sq_q  <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn_pay   = pay_q;
	assign dn_sq    = sq_q;

endmodule

`default_nettype wire
